// ===== sv/cttok_pkg.sv =====
`timescale 1ns / 1ps

package cttok_pkg;

	localparam int unsigned BufferBytes = 65536;
	localparam int unsigned PosW = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;
	localparam int unsigned LenW = PosW + 1;

	localparam logic [2:0] KIND_COMMENT = 3'd0;
	localparam logic [2:0] KIND_ASSIGN  = 3'd1;
	localparam logic [2:0] KIND_SPACE   = 3'd2;
	localparam logic [2:0] KIND_ILLEGAL = 3'd3;
	localparam logic [2:0] KIND_RAW     = 3'd4;
	localparam logic [2:0] KIND_QUOTED  = 3'd5;
	localparam logic [2:0] KIND_CR      = 3'd6;
	localparam logic [2:0] KIND_LF      = 3'd7;

	typedef struct packed {
		logic [2:0]      kind;
		logic [15:0]     offset;
		logic [16:0]     length;
		logic            final_of_run;
	} token_t;

	typedef struct packed {
		token_t     tok0;
		token_t     tok1;
		logic [1:0] count;
	} result_t;

endpackage

// ===== sv/cttok_byte_if.sv =====
`timescale 1ns / 1ps

interface cttok_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_buffer;

	modport source (output valid, output text_byte, output end_of_buffer, input ready);
	modport sink (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

// ===== sv/cttok_token_if.sv =====
`timescale 1ns / 1ps

interface cttok_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] token_offset;
	logic [16:0] token_length;
	logic        final_of_run;

	modport source (output valid, output token_kind, output token_offset,
		output token_length, output final_of_run, input ready);
	modport sink (input valid, input token_kind, input token_offset,
		input token_length, input final_of_run, output ready);
endinterface

// ===== sv/cttok_core.sv =====
`timescale 1ns / 1ps

module cttok_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          text_byte,
	input  logic                end_of_buffer,
	input  logic                advance,
	output cttok_pkg::result_t  result
);

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_RAW    = 3'b010,
		MODE_STRING = 3'b100
	} mode_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	mode_t                       mode_q, mode_d;
	logic [cttok_pkg::PosW-1:0]  pos_q;
	logic [cttok_pkg::PosW-1:0]  begin_q, begin_d;
	logic                        last;
	logic                        alnum;
	logic [cttok_pkg::LenW-1:0]  len_incl;
	logic [cttok_pkg::LenW-1:0]  len_excl;
	logic [2:0]                  single_kind;
	cttok_pkg::token_t           t0, t1;
	logic [1:0]                  n;

	function automatic logic is_alnum(input logic [7:0] c);
		logic [7:0] z;
		z = c | CASE_BIT;
		return (z >= 8'h61 && z <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic [2:0] classify(input logic [7:0] c);
		logic [2:0] k;
		unique case (c)
			CH_HASH:         k = cttok_pkg::KIND_COMMENT;
			CH_COLON, CH_EQ: k = cttok_pkg::KIND_ASSIGN;
			CH_SPACE, CH_TAB: k = cttok_pkg::KIND_SPACE;
			CH_CR:           k = cttok_pkg::KIND_CR;
			CH_LF:           k = cttok_pkg::KIND_LF;
			default:         k = cttok_pkg::KIND_ILLEGAL;
		endcase
		return k;
	endfunction

	function automatic cttok_pkg::token_t make_tok(input logic [2:0] kind,
			input logic [15:0] offset, input logic [16:0] length);
		cttok_pkg::token_t t;
		t.kind         = kind;
		t.offset       = offset;
		t.length       = length;
		t.final_of_run = 1'b0;
		return t;
	endfunction

	assign last = end_of_buffer ||
		(pos_q == cttok_pkg::PosW'(cttok_pkg::BufferBytes - 1));
	assign alnum       = is_alnum(text_byte);
	assign single_kind = classify(text_byte);
	assign len_incl    = {1'b0, pos_q} + cttok_pkg::LenW'(1) - {1'b0, begin_q};
	assign len_excl    = {1'b0, pos_q} - {1'b0, begin_q};

	always_comb begin
		t0      = make_tok(cttok_pkg::KIND_COMMENT, 16'd0, 17'd0);
		t1      = make_tok(cttok_pkg::KIND_COMMENT, 16'd0, 17'd0);
		n       = 2'd0;
		mode_d  = mode_q;
		begin_d = begin_q;
		unique case (mode_q)
			MODE_RAW: begin
				if (alnum) begin
					if (last) begin
						t0 = make_tok(cttok_pkg::KIND_RAW, 16'(begin_q), 17'(len_incl));
						n  = 2'd1;
					end
				end else begin
					t0     = make_tok(cttok_pkg::KIND_RAW, 16'(begin_q), 17'(len_excl));
					mode_d = MODE_IDLE;
					if (text_byte == CH_QUOTE) begin
						begin_d = pos_q;
						mode_d  = MODE_STRING;
						n       = 2'd1;
					end else begin
						t1 = make_tok(single_kind, 16'd0, 17'd0);
						n  = 2'd2;
					end
				end
			end
			MODE_STRING: begin
				if (text_byte == CH_QUOTE) begin
					t0     = make_tok(cttok_pkg::KIND_QUOTED, 16'(begin_q), 17'(len_incl));
					n      = 2'd1;
					mode_d = MODE_IDLE;
				end else if (text_byte == CH_CR || text_byte == CH_LF) begin
					t0     = make_tok(single_kind, 16'd0, 17'd0);
					n      = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (text_byte == CH_QUOTE) begin
					begin_d = pos_q;
					mode_d  = MODE_STRING;
				end else if (alnum) begin
					begin_d = pos_q;
					if (last) begin
						t0 = make_tok(cttok_pkg::KIND_RAW, 16'(pos_q), 17'd1);
						n  = 2'd1;
					end else begin
						mode_d = MODE_RAW;
					end
				end else begin
					t0 = make_tok(single_kind, 16'd0, 17'd0);
					n  = 2'd1;
				end
			end
		endcase
		if (last) begin
			mode_d = MODE_IDLE;
		end
		if (n == 2'd1) begin
			t0.final_of_run = 1'b1;
		end
		if (n == 2'd2) begin
			t1.final_of_run = 1'b1;
		end
	end

	assign result.tok0  = t0;
	assign result.tok1  = t1;
	assign result.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			begin_q <= begin_d;
			pos_q   <= last ? '0 : pos_q + cttok_pkg::PosW'(1);
		end
	end

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q)) else $error("scan mode lost its one-hot code");
	a_begin_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (begin_q <= pos_q))
		else $error("open token starts beyond the current position");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last) |=> (mode_q == MODE_IDLE && pos_q == '0))
		else $error("buffer end did not return to idle at offset zero");

endmodule

// ===== sv/config_text_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Channel  Role    Payload
// bytes    sink    text_byte[7:0], end_of_buffer
// tokens   source  token_kind[2:0], token_offset[15:0], token_length[16:0], final_of_run
//
// One byte is accepted per cycle while the result buffer has room for its tokens.
// While the sink is ready, one token drains per cycle; bytes that cause two set the rate.
// A two-entry result buffer holds tokens while the sink stalls; the input register
// then holds the next byte and ready drops. Reset is asynchronous and active low,
// and brings the tokenizer to idle at offset zero.

module config_text_tokenizer_top (
	input  logic               clk,
	input  logic               arst_n,
	cttok_byte_if.sink         bytes,
	cttok_token_if.source      tokens
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eob_s1;
	logic               adv;
	logic               pop;
	logic [1:0]         occ_q, occ_after;
	logic [2:0]         fill;
	logic [1:0]         new_n;
	cttok_pkg::token_t  slot0_q, slot1_q, rem;
	cttok_pkg::result_t res;

	cttok_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_byte     (byte_s1),
		.end_of_buffer (eob_s1),
		.advance       (adv),
		.result        (res)
	);

	assign pop       = (occ_q != 2'd0) && tokens.ready;
	assign occ_after = occ_q - {1'b0, pop};
	assign fill      = {1'b0, occ_after} + {1'b0, res.count};
	assign adv       = valid_s1 && (fill <= 3'd2);
	assign new_n     = adv ? res.count : 2'd0;
	assign rem       = pop ? slot1_q : slot0_q;

	assign bytes.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.text_byte;
			eob_s1  <= bytes.end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_after + new_n;
		end
	end

	always_ff @(posedge clk) begin
		unique case (occ_after)
			2'd0: begin
				slot0_q <= res.tok0;
				slot1_q <= res.tok1;
			end
			2'd1: begin
				slot0_q <= rem;
				slot1_q <= res.tok0;
			end
			default: begin
				slot0_q <= slot0_q;
				slot1_q <= slot1_q;
			end
		endcase
	end

	assign tokens.valid        = (occ_q != 2'd0);
	assign tokens.token_kind   = slot0_q.kind;
	assign tokens.token_offset = slot0_q.offset;
	assign tokens.token_length = slot0_q.length;
	assign tokens.final_of_run = slot0_q.final_of_run;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q != 2'd3) else $error("result buffer overfilled");
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.count != 2'd0) |=> (occ_q != 2'd0))
		else $error("tokens of an advanced byte went missing");
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.count == 2'd2) |=> (occ_q == 2'd2))
		else $error("second token of a byte was not buffered");
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> valid_s1)
		else $error("input stalled with an empty input register");

endmodule
